### hdl/ps2_mouse_packet_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder assertion macros
// Shared helpers for the concurrent checks in the decoder modules. Each
// macro expects signals named aclk and aresetn in the calling scope.
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ps2md_pkg.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared constants, codes and the event record passed from the packet unit
// to the event emitter.
// ---------------------------------------------------------------------------
`default_nettype none

package ps2md_pkg;

    // Coordinate and bound width.
    localparam int COORD_W = 16;

    // Bit positions inside the first (flags) byte of a packet.
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MIDDLE = 2;
    localparam int FLAG_SYNC   = 3;
    localparam int FLAG_X_OVF  = 6;
    localparam int FLAG_Y_OVF  = 7;

    // Configuration register indexes.
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_AREA_WIDTH  = 1'b0;
    localparam cfg_index_t REG_AREA_HEIGHT = 1'b1;

    // Result event kinds.
    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    // Button codes. Event slots use the same numbering: slot 0 is the
    // movement event, slots 1 to 3 are the left, middle and right buttons.
    typedef logic [1:0] button_id_t;
    localparam button_id_t BTN_NONE   = 2'd0;
    localparam button_id_t BTN_LEFT   = 2'd1;
    localparam button_id_t BTN_MIDDLE = 2'd2;
    localparam button_id_t BTN_RIGHT  = 2'd3;

    // Packet byte counter values.
    typedef logic [1:0] byte_pos_t;
    localparam byte_pos_t BYTE_FLAGS = 2'd0;
    localparam byte_pos_t BYTE_DX    = 2'd1;
    localparam byte_pos_t BYTE_DY    = 2'd2;

    // Reciprocal of three for a 16-bit dividend: (h * 43691) >> 17 == h / 3.
    localparam int          DIV3_SHIFT = 17;
    localparam logic [16:0] DIV3_MUL   = 17'd43691;

    // Events produced by one packet: one mask bit per slot, the new button
    // levels (left, middle, right from bit 0) and the updated position.
    typedef struct packed {
        logic [3:0]         mask;
        logic [2:0]         press;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } ev_rec_t;

endpackage

`default_nettype wire

### hdl/ps2_mouse_packet_decoder_top.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder top level
// Turns a stream of mouse bytes into pointer movement and button events.
// ---------------------------------------------------------------------------
// Usage: one mouse byte is accepted per cycle while s_ready is high. Each
// byte is registered, then processed from the input register; a byte that
// completes a valid packet writes up to four events into the emitter, which
// presents them one per cycle while m_ready is high, the first one valid once
// the byte has passed the input register and the emitter's pending mask
// register. A packet-completing byte waits in the input register until the
// previous packet's events have all been taken. Bound writes on the cfg
// channel are always ready, and a nonzero one moves the pointer to three
// quarters of the width and a third of the height; write them only while no
// byte or event is in flight.
`default_nettype none

module ps2_mouse_packet_decoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ps2md_pkg::event_kind_t             m_event_kind,
    output ps2md_pkg::button_id_t              m_button_id,
    output logic [ps2md_pkg::COORD_W-1:0]      m_pos_x_out,
    output logic [ps2md_pkg::COORD_W-1:0]      m_pos_y_out,
    output logic                               m_last_event,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire ps2md_pkg::cfg_index_t         cfg_index,
    input  wire logic [ps2md_pkg::COORD_W-1:0] cfg_data
);
    import ps2md_pkg::*;

    ev_rec_t rec;
    logic    load;
    logic    load_ok;

    // Packet assembly, position update and event record.
    ps2md_packet_unit u_packet (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rec         (rec),
        .load        (load),
        .load_ok     (load_ok)
    );

    // Event serialization onto the result channel.
    ps2md_event_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rec          (rec),
        .load         (load),
        .load_ok      (load_ok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_button_id  (m_button_id),
        .m_pos_x_out  (m_pos_x_out),
        .m_pos_y_out  (m_pos_y_out),
        .m_last_event (m_last_event)
    );

endmodule

`default_nettype wire

### hdl/ps2md_packet_unit.sv
// ---------------------------------------------------------------------------
// PS/2 mouse packet unit
// Registers incoming bytes, assembles three-byte packets, clamps the pointer
// position to the configured area and builds the event record of a packet.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_decoder_top_assert.svh"

module ps2md_packet_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire ps2md_pkg::cfg_index_t         cfg_index,
    input  wire logic [ps2md_pkg::COORD_W-1:0] cfg_data,
    output ps2md_pkg::ev_rec_t                 rec,
    output logic                               load,
    input  wire logic                          load_ok
);
    import ps2md_pkg::*;

    logic [7:0]         byte_reg, byte_next;
    logic               byte_valid_reg, byte_valid_next;
    byte_pos_t          byte_pos_reg, byte_pos_next;
    logic [7:0]         store0_reg, store0_next;
    logic [7:0]         store1_reg, store1_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic [2:0]         levels_reg, levels_next;
    logic [COORD_W-1:0] width_reg, width_next;
    logic [COORD_W-1:0] height_reg, height_next;

    logic               completes;
    logic               proceed;
    logic               overflow;
    logic [COORD_W+1:0] sum_x, sum_y;
    logic [COORD_W-1:0] new_x, new_y;
    logic [2:0]         now_levels;
    logic [COORD_W+16:0] div3_prod;

    // Clamp a signed sum to 0 .. bound-1.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W+1:0] v,
        input logic [COORD_W-1:0] bound
    );
        logic [COORD_W-1:0] r;
        if (v[COORD_W+1] || (v == '0)) begin
            r = '0;
        end else if (v >= {2'b00, bound}) begin
            r = bound - 1'b1;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // Packet arithmetic on the registered byte and the stored packet bytes.
    always_comb begin
        completes  = (byte_pos_reg == BYTE_DY);
        proceed    = byte_valid_reg && (!completes || load_ok);
        s_ready    = !byte_valid_reg || proceed;
        cfg_ready  = 1'b1;
        overflow   = store0_reg[FLAG_X_OVF] || store0_reg[FLAG_Y_OVF];
        sum_x      = {2'b00, pos_x_reg} + {{(COORD_W-6){store1_reg[7]}}, store1_reg};
        sum_y      = {2'b00, pos_y_reg} - {{(COORD_W-6){byte_reg[7]}}, byte_reg};
        new_x      = clamp_coord(sum_x, width_reg);
        new_y      = clamp_coord(sum_y, height_reg);
        now_levels = {store0_reg[FLAG_RIGHT], store0_reg[FLAG_MIDDLE], store0_reg[FLAG_LEFT]};
        load       = proceed && completes && !overflow;
    end

    // Event record for the emitter.
    always_comb begin
        rec.mask  = {now_levels ^ levels_reg, (new_x != pos_x_reg) || (new_y != pos_y_reg)};
        rec.press = now_levels;
        rec.x     = new_x;
        rec.y     = new_y;
    end

    // Next-state logic for the byte register, packet assembly and config.
    always_comb begin
        byte_valid_next = (byte_valid_reg && !proceed) || (s_valid && s_ready);
        byte_next       = (s_valid && s_ready) ? s_data_byte : byte_reg;
        byte_pos_next   = byte_pos_reg;
        store0_next     = store0_reg;
        store1_next     = store1_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        levels_next     = levels_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        div3_prod       = '0;

        if (proceed) begin
            unique case (byte_pos_reg)
                BYTE_FLAGS: begin
                    // A first byte without the always-one bit is dropped.
                    if (byte_reg[FLAG_SYNC]) begin
                        store0_next   = byte_reg;
                        byte_pos_next = BYTE_DX;
                    end
                end
                BYTE_DX: begin
                    store1_next   = byte_reg;
                    byte_pos_next = BYTE_DY;
                end
                default: begin
                    byte_pos_next = BYTE_FLAGS;
                    if (!overflow) begin
                        pos_x_next  = new_x;
                        pos_y_next  = new_y;
                        levels_next = now_levels;
                    end
                end
            endcase
        end

        // A nonzero bound write sets x to 3/4 width and y to 1/3 height.
        if (cfg_valid && (cfg_data != '0)) begin
            if (cfg_index == REG_AREA_WIDTH) begin
                width_next = cfg_data;
            end else begin
                height_next = cfg_data;
            end
            div3_prod  = (COORD_W+17)'(height_next) * (COORD_W+17)'(DIV3_MUL);
            pos_x_next = width_next - {2'b00, width_next[COORD_W-1:2]};
            pos_y_next = div3_prod[COORD_W+DIV3_SHIFT-1:DIV3_SHIFT];
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
            byte_pos_reg   <= BYTE_FLAGS;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            levels_reg     <= '0;
            width_reg      <= COORD_W'(1);
            height_reg     <= COORD_W'(1);
        end else begin
            byte_valid_reg <= byte_valid_next;
            byte_pos_reg   <= byte_pos_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            levels_reg     <= levels_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        store0_reg <= store0_next;
        store1_reg <= store1_next;
    end

    `PMD_ASSERT_IMP(a_pos_range, 1'b1, byte_pos_reg != 2'd3, "byte counter out of range")
    `PMD_ASSERT_IMP(a_stall_only_final, !s_ready,
        byte_valid_reg && (byte_pos_reg == BYTE_DY), "input stalled on a non-final byte")
    `PMD_ASSERT_NXT(a_resync, proceed && (byte_pos_reg == BYTE_FLAGS) && !byte_reg[FLAG_SYNC],
        byte_pos_reg == BYTE_FLAGS, "unsynchronized first byte was not dropped")

endmodule

`default_nettype wire

### hdl/ps2md_event_emitter.sv
// ---------------------------------------------------------------------------
// PS/2 mouse event emitter
// Holds the event record of one packet and hands out its events one per
// cycle while m_ready is high, movement first, then left, middle and right button changes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ps2_mouse_packet_decoder_top_assert.svh"

module ps2md_event_emitter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ps2md_pkg::ev_rec_t            rec,
    input  wire logic                          load,
    output logic                               load_ok,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ps2md_pkg::event_kind_t             m_event_kind,
    output ps2md_pkg::button_id_t              m_button_id,
    output logic [ps2md_pkg::COORD_W-1:0]      m_pos_x_out,
    output logic [ps2md_pkg::COORD_W-1:0]      m_pos_y_out,
    output logic                               m_last_event
);
    import ps2md_pkg::*;

    logic [3:0]         mask_reg, mask_next;
    logic [2:0]         press_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [3:0]         rest;
    button_id_t         sel;

    // Pick the lowest pending slot; the slot number is the button code.
    always_comb begin
        if (mask_reg[0]) begin
            sel = BTN_NONE;
        end else if (mask_reg[1]) begin
            sel = BTN_LEFT;
        end else if (mask_reg[2]) begin
            sel = BTN_MIDDLE;
        end else begin
            sel = BTN_RIGHT;
        end
        rest = mask_reg & (mask_reg - 4'd1);
    end

    // Result channel outputs.
    always_comb begin
        m_valid      = |mask_reg;
        m_button_id  = sel;
        m_pos_x_out  = x_reg;
        m_pos_y_out  = y_reg;
        m_last_event = (rest == '0);
        if (sel == BTN_NONE) begin
            m_event_kind = EV_MOVE;
        end else if (press_reg[2'(sel - BTN_LEFT)]) begin
            m_event_kind = EV_PRESS;
        end else begin
            m_event_kind = EV_RELEASE;
        end
        load_ok = !m_valid || (m_ready && (rest == '0));
    end

    // Pending mask: reload on a new record, otherwise retire the sent slot.
    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = rec.mask;
        end else if (m_valid && m_ready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    // Record payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            press_reg <= rec.press;
            x_reg     <= rec.x;
            y_reg     <= rec.y;
        end
    end

    `PMD_ASSERT_IMP(a_load_free, load, load_ok, "record loaded while events still pending")
    `PMD_ASSERT_NXT(a_more_pending, m_valid && m_ready && !m_last_event && !load,
        m_valid, "events lost before the last one")
    `PMD_ASSERT_NXT(a_empty_record, load && (rec.mask == '0),
        !m_valid, "empty record produced an event")

endmodule

`default_nettype wire
